// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int PRIO_W = 8;
  localparam int TAG_W  = 16;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_PUSHED = 2'd0;
  localparam logic [STAT_W-1:0] ST_POPPED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  // operation broadcast to every cell
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic              valid;
    logic              gt;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } link_t;

endpackage

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted array, shifts right on insert and left on pop
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  spq_pkg::cmd_t  cmd,
  input  spq_pkg::link_t left_link,
  input  spq_pkg::link_t right_link,
  output spq_pkg::link_t own_link
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [spq_pkg::PRIO_W-1:0] prio_r;
  logic [spq_pkg::PRIO_W-1:0] prio_nxt;
  logic [spq_pkg::TAG_W-1:0]  tag_r;
  logic [spq_pkg::TAG_W-1:0]  tag_nxt;
  logic                       gt;

  // empty slots count as greater so the insert point lands on them
  assign gt = !valid_r || (prio_r > cmd.prio);

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    tag_nxt   = tag_r;
    if (cmd.push && gt) begin
      if (!left_link.gt) begin
        valid_nxt = 1'b1;
        prio_nxt  = cmd.prio;
        tag_nxt   = cmd.tag;
      end else begin
        valid_nxt = left_link.valid;
        prio_nxt  = left_link.prio;
        tag_nxt   = left_link.tag;
      end
    end else if (cmd.pop) begin
      valid_nxt = right_link.valid;
      prio_nxt  = right_link.prio;
      tag_nxt   = right_link.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign own_link = '{valid: valid_r, gt: gt, prio: prio_r, tag: tag_r};

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// sorted priority queue built as a row of shifting cells
// ----------------------------------------------------------------------------
// usage:
//   in channel carries an operation: opcode push with priority and tag, or
//   pop. every input transfer yields exactly one out transfer with status,
//   popped priority and tag (zero unless popped), occupancy and empty flag.
//   pushes land after all entries of equal or lower priority value, so
//   equal priorities leave in arrival order. a push to a full queue and a
//   pop of an empty one change nothing and report their status.
//   the result is registered and valid in the cycle after the input
//   transfer. throughput: one operation per cycle while out_ready is high;
//   every cell compares the broadcast priority and shifts in the same
//   cycle, and the result register sits between the two channels.
//   when out_ready is low the result waits in the output register and
//   in_ready drops until it is taken.
//   reset (rst_n low, synchronous) empties the queue and drops out_valid.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [spq_pkg::PRIO_W-1:0]    in_entry_priority,
  input  logic [spq_pkg::TAG_W-1:0]     in_entry_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spq_pkg::STAT_W-1:0]    out_status,
  output logic [spq_pkg::PRIO_W-1:0]    out_priority,
  output logic [spq_pkg::TAG_W-1:0]     out_tag,
  output logic [spq_pkg::OCC_W-1:0]     out_occupancy,
  output logic                          out_queue_empty
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                       in_xfer;
  logic                       full;
  logic                       empty;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;
  logic [31:0]                count_ext;
  spq_pkg::cmd_t              cmd;
  spq_pkg::link_t             links [DEPTH];
  spq_pkg::link_t             edge_left;
  spq_pkg::link_t             edge_right;

  logic                       out_valid_r;
  logic [spq_pkg::STAT_W-1:0] status_r;
  logic [spq_pkg::STAT_W-1:0] status_nxt;
  logic [spq_pkg::PRIO_W-1:0] prio_r;
  logic [spq_pkg::PRIO_W-1:0] prio_nxt;
  logic [spq_pkg::TAG_W-1:0]  tag_r;
  logic [spq_pkg::TAG_W-1:0]  tag_nxt;
  logic [spq_pkg::OCC_W-1:0]  occ_r;
  logic                       qempty_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  assign cmd.push = in_xfer && (in_opcode == spq_pkg::OP_PUSH) && !full;
  assign cmd.pop  = in_xfer && (in_opcode == spq_pkg::OP_POP) && !empty;
  assign cmd.prio = in_entry_priority;
  assign cmd.tag  = in_entry_tag;

  // left edge never shifts in, right edge feeds an empty slot
  assign edge_left  = '{valid: 1'b0, gt: 1'b0, prio: '0, tag: '0};
  assign edge_right = '{valid: 1'b0, gt: 1'b1, prio: '0, tag: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::link_t lft;
    spq_pkg::link_t rgt;
    if (i == 0) begin : g_first
      assign lft = edge_left;
    end else begin : g_mid_l
      assign lft = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rgt = edge_right;
    end else begin : g_mid_r
      assign rgt = links[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_link  (lft),
      .right_link (rgt),
      .own_link   (links[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_PUSHED;
    prio_nxt   = '0;
    tag_nxt    = '0;
    unique case (in_opcode)
      spq_pkg::OP_PUSH: begin
        if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          status_nxt = spq_pkg::ST_PUSHED;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      spq_pkg::OP_POP: begin
        if (empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          status_nxt = spq_pkg::ST_POPPED;
          prio_nxt   = links[0].prio;
          tag_nxt    = links[0].tag;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = spq_pkg::ST_PUSHED;
      end
    endcase
  end

  assign count_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r <= count_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r <= status_nxt;
      prio_r   <= prio_nxt;
      tag_r    <= tag_nxt;
      occ_r    <= count_ext[spq_pkg::OCC_W-1:0];
      qempty_r <= (count_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_priority    = prio_r;
  assign out_tag         = tag_r;
  assign out_occupancy   = occ_r;
  assign out_queue_empty = qempty_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count beyond depth");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    links[0].valid == !empty)
    else $error("head slot valid disagrees with count");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_opcode == spq_pkg::OP_PUSH) && full
    |=> out_status == spq_pkg::ST_FULL && $stable(count_r))
    else $error("push on full queue not rejected");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_opcode == spq_pkg::OP_POP) && empty
    |=> out_status == spq_pkg::ST_EMPTY && out_queue_empty)
    else $error("pop on empty queue misreported");
`endif

endmodule
